[rtl/texel_block_decoder_4bpp_defines.svh]
`ifndef TEXEL_BLOCK_DECODER_4BPP_DEFINES_SVH
`define TEXEL_BLOCK_DECODER_4BPP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("texel block decoder check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("texel block decoder check failed");

`endif

[rtl/tbd_pkg.sv]
package tbd_pkg;

    localparam int MAX_SIDE_LOG2 = 6;
    localparam int XW = MAX_SIDE_LOG2;
    localparam int BW = MAX_SIDE_LOG2 - 2;
    localparam int MW = 2 * MAX_SIDE_LOG2 - 4;
    localparam int IW = MW + 1;
    localparam int LW = 3;
    localparam logic [LW-1:0] CFG_RESET = LW'(6);

    typedef enum logic {
        OP_LOAD,
        OP_DECODE
    } t_op;

    typedef enum logic {
        CFG_WIDTH,
        CFG_HEIGHT
    } t_cfg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    typedef struct packed {
        logic          en;
        logic          bank;
        logic [MW-1:0] addr;
        logic [31:0]   data;
    } t_wr;

    typedef struct packed {
        logic          en;
        logic [MW-1:0] mod_addr;
        logic [MW-1:0] c0_addr;
        logic [MW-1:0] c1_addr;
    } t_rd;

    typedef struct packed {
        logic [1:0] wx;
        logic [1:0] wy;
        logic [3:0] sel_idx;
        logic       own_dx;
        logic       own_dy;
    } t_side;

    function automatic logic [LW-1:0] eff_log2(input logic [LW-1:0] v);
        logic [LW-1:0] e;
        e = v;
        if (v < LW'(2)) e = LW'(2);
        if (v > LW'(MAX_SIDE_LOG2)) e = LW'(MAX_SIDE_LOG2);
        return e;
    endfunction

    function automatic logic [MW-1:0] block_addr(input logic [BW-1:0] bx,
                                                 input logic [BW-1:0] by,
                                                 input logic [LW-1:0] lw,
                                                 input logic [LW-1:0] lh);
        logic [LW-1:0] lmin;
        logic [MW-1:0] hx;
        logic [MW-1:0] hy;
        logic [MW-1:0] m;
        lmin = (lw < lh) ? lw : lh;
        hx = MW'(bx) << lh;
        hy = MW'(by) << lw;
        for (int b = 0; b < MW; b++) begin
            if (b < 2 * int'(lmin)) begin
                m[b] = (b % 2 == 0) ? by[b/2] : bx[b/2];
            end else if (lw > lh) begin
                m[b] = hx[b];
            end else if (lh > lw) begin
                m[b] = hy[b];
            end else begin
                m[b] = 1'b0;
            end
        end
        return m;
    endfunction

    function automatic t_rgba unpack_colour(input logic [15:0] v);
        t_rgba c;
        if (v[15]) begin
            c.a = 8'hFF;
            c.r = {v[14:10], 3'b000};
            c.g = {v[9:5], 3'b000};
            c.b = {v[4:0], 3'b000};
        end else begin
            c.a = {v[14:12], 5'b00000};
            c.r = {v[11:8], 4'b0000};
            c.g = {v[7:4], 4'b0000};
            c.b = {v[3:0], 4'b0000};
        end
        return c;
    endfunction

    function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] t,
                                        input logic [7:0] w);
        logic [16:0] acc;
        acc = 17'(s) * 17'(8'd255 - w) + 17'(t) * 17'(w);
        return acc[15:8];
    endfunction

    function automatic t_rgba mix_rgba(input t_rgba s, input t_rgba t, input logic [7:0] w);
        t_rgba c;
        c.r = mix8(s.r, t.r, w);
        c.g = mix8(s.g, t.g, w);
        c.b = mix8(s.b, t.b, w);
        c.a = mix8(s.a, t.a, w);
        return c;
    endfunction

endpackage

[rtl/tbd_in_if.sv]
interface tbd_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [8:0]  word_index;
    logic [31:0] word_data;
    logic [5:0]  texel_x;
    logic [5:0]  texel_y;

    modport source (output valid, op, word_index, word_data, texel_x, texel_y, input ready);
    modport sink (input valid, op, word_index, word_data, texel_x, texel_y, output ready);
endinterface

[rtl/tbd_out_if.sv]
interface tbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

[rtl/texel_block_decoder_4bpp.sv]
// Texel block decoder, 4 bits per pixel.
// Input channel i_in carries items: a load (op 0) writes word_data at the
// twiddled store address word_index; a decode (op 1) names texel_x/texel_y
// and yields one RGBA item on o_out. Loads yield nothing.
// Configuration: i_cfg_we writes i_cfg_data into width_log2 (index 0) or
// height_log2 (index 1); write only while the block is idle.
// The store is split into a modulation bank and a colour bank; the colour
// bank has two read ports. A decode reads the top and then the bottom row
// of two neighbour colour words in the issue stage; a load only writes.
// A new item is taken as the issue stage finishes the last; a decode's
// first row read waits for room in the filter. Loads are ordered with
// decodes through the issue stage; results pass filter regs d, h, v, o.
// Reset clears the pipeline and sets both sizes to 64 texels; the store is
// not cleared and must be loaded before it is decoded.
// When o_out stalls, the result holds and the pipeline behind it keeps
// filling its empty stages before i_in.ready drops.
module texel_block_decoder_4bpp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tbd_in_if.sink                    i_in,
    tbd_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [tbd_pkg::LW-1:0]    i_cfg_data
);
    import tbd_pkg::*;

    t_wr         wr;
    t_rd         rd;
    t_side       side;
    logic        d_fill;
    logic        d_ready;
    logic [31:0] mod_q, c0_q, c1_q;

    tbd_issue u_issue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_d_ready   (d_ready),
        .o_wr        (wr),
        .o_rd        (rd),
        .o_d_fill    (d_fill),
        .o_side      (side)
    );

    tbd_store u_store (
        .i_clk (i_clk),
        .i_wr  (wr),
        .i_rd  (rd),
        .o_mod (mod_q),
        .o_c0  (c0_q),
        .o_c1  (c1_q)
    );

    tbd_filter u_filter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_d_fill  (d_fill),
        .i_side    (side),
        .i_mod     (mod_q),
        .i_c0      (c0_q),
        .i_c1      (c1_q),
        .o_d_ready (d_ready),
        .o_out     (o_out)
    );
endmodule

[rtl/tbd_store.sv]
module tbd_store (
    input  logic                      i_clk,
    input  tbd_pkg::t_wr              i_wr,
    input  tbd_pkg::t_rd              i_rd,
    output logic [31:0]               o_mod,
    output logic [31:0]               o_c0,
    output logic [31:0]               o_c1
);
    import tbd_pkg::*;

    logic [31:0] mod_mem [2**MW];
    logic [31:0] col_mem [2**MW];
    logic [31:0] r_mod;
    logic [31:0] r_c0;
    logic [31:0] r_c1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && !i_wr.bank) begin
            mod_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_wr.en && i_wr.bank) begin
            col_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_mod <= mod_mem[i_rd.mod_addr];
            r_c0  <= col_mem[i_rd.c0_addr];
            r_c1  <= col_mem[i_rd.c1_addr];
        end
    end

    assign o_mod = r_mod;
    assign o_c0  = r_c0;
    assign o_c1  = r_c1;
endmodule

[rtl/tbd_issue.sv]
module tbd_issue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tbd_in_if.sink                    i_in,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [tbd_pkg::LW-1:0]    i_cfg_data,
    input  logic                      i_d_ready,
    output tbd_pkg::t_wr              o_wr,
    output tbd_pkg::t_rd              o_rd,
    output logic                      o_d_fill,
    output tbd_pkg::t_side            o_side
);
    import tbd_pkg::*;

    logic          r_valid;
    logic          r_phase;
    t_op           r_op;
    logic [IW-1:0] r_word_index;
    logic [31:0]   r_word_data;
    logic [XW-1:0] r_x;
    logic [XW-1:0] r_y;
    logic [LW-1:0] r_width;
    logic [LW-1:0] r_height;
    logic          n_phase;

    logic [LW-1:0] wl, hl, lw, lh;
    logic [XW-1:0] x, y;
    logic [BW-1:0] bx, by, maxx, maxy, cx0, cx1, cy0, cy1, row;
    logic [1:0]    ix, iy;
    logic          fire0, fire1, done, accept;

    always_comb begin
        wl   = eff_log2(r_width);
        hl   = eff_log2(r_height);
        lw   = wl - LW'(2);
        lh   = hl - LW'(2);
        x    = r_x & XW'(((XW+1)'(1) << wl) - (XW+1)'(1));
        y    = r_y & XW'(((XW+1)'(1) << hl) - (XW+1)'(1));
        bx   = x[XW-1:2];
        by   = y[XW-1:2];
        ix   = x[1:0];
        iy   = y[1:0];
        maxx = BW'(((BW+1)'(1) << lw) - (BW+1)'(1));
        maxy = BW'(((BW+1)'(1) << lh) - (BW+1)'(1));
        cx0  = ix[1] ? bx : ((bx == '0) ? bx : bx - BW'(1));
        cx1  = ix[1] ? ((bx == maxx) ? bx : bx + BW'(1)) : bx;
        cy0  = iy[1] ? by : ((by == '0) ? by : by - BW'(1));
        cy1  = iy[1] ? ((by == maxy) ? by : by + BW'(1)) : by;
        row  = r_phase ? cy1 : cy0;
    end

    always_comb begin
        fire0  = r_valid && (r_op == OP_DECODE) && !r_phase && i_d_ready;
        fire1  = r_valid && (r_op == OP_DECODE) && r_phase;
        done   = (r_valid && (r_op == OP_LOAD)) || fire1;
        accept = i_in.valid && i_in.ready;
        if (done) begin
            n_phase = 1'b0;
        end else if (fire0) begin
            n_phase = 1'b1;
        end else begin
            n_phase = r_phase;
        end
    end

    assign i_in.ready = !r_valid || done;

    always_comb begin
        o_wr.en   = r_valid && (r_op == OP_LOAD);
        o_wr.bank = r_word_index[0];
        o_wr.addr = r_word_index[IW-1:1];
        o_wr.data = r_word_data;

        o_rd.en       = fire0 || fire1;
        o_rd.mod_addr = block_addr(bx, by, lw, lh);
        o_rd.c0_addr  = block_addr(cx0, row, lw, lh);
        o_rd.c1_addr  = block_addr(cx1, row, lw, lh);

        o_d_fill       = fire1;
        o_side.wx      = ix + 2'd2;
        o_side.wy      = iy + 2'd2;
        o_side.sel_idx = {iy, ix};
        o_side.own_dx  = !ix[1];
        o_side.own_dy  = !iy[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_phase  <= 1'b0;
            r_width  <= CFG_RESET;
            r_height <= CFG_RESET;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (done) begin
                r_valid <= 1'b0;
            end
            r_phase <= n_phase;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_width  <= r_width;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= t_op'(i_in.op);
            r_word_index <= i_in.word_index;
            r_word_data  <= i_in.word_data;
            r_x          <= i_in.texel_x;
            r_y          <= i_in.texel_y;
        end
    end
endmodule

[rtl/tbd_filter.sv]
module tbd_filter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_d_fill,
    input  tbd_pkg::t_side     i_side,
    input  logic [31:0]        i_mod,
    input  logic [31:0]        i_c0,
    input  logic [31:0]        i_c1,
    output logic               o_d_ready,
    tbd_out_if.source          o_out
);
    import tbd_pkg::*;

    logic        r_d_valid;
    logic [31:0] r_p0_c0;
    logic [31:0] r_p0_c1;
    logic [31:0] r_p0_mod;
    t_side       r_d_side;

    logic        r_h_valid;
    t_rgba       r_h_ta, r_h_ba, r_h_tb, r_h_bb;
    logic [1:0]  r_h_wy;
    logic [1:0]  r_h_sel;
    logic        r_h_mode;

    logic        r_v_valid;
    t_rgba       r_v_a, r_v_b;
    logic [1:0]  r_v_sel;
    logic        r_v_mode;

    logic        r_o_valid;
    t_rgba       r_o_px;

    logic        rdy_o, rdy_v, rdy_h;
    logic [31:0] own;
    logic [7:0]  ax;
    logic [1:0]  sel;
    t_rgba       n_ta, n_ba, n_tb, n_bb, n_px;

    always_comb begin
        rdy_o     = !r_o_valid || o_out.ready;
        rdy_v     = !r_v_valid || rdy_o;
        rdy_h     = !r_h_valid || rdy_v;
        o_d_ready = !r_d_valid || rdy_h;
    end

    always_comb begin
        if (r_d_side.own_dy) begin
            own = r_d_side.own_dx ? i_c1 : i_c0;
        end else begin
            own = r_d_side.own_dx ? r_p0_c1 : r_p0_c0;
        end
        sel  = r_p0_mod[{r_d_side.sel_idx, 1'b0} +: 2];
        ax   = {r_d_side.wx, 6'b000000};
        n_ta = mix_rgba(unpack_colour({r_p0_c0[15:1], 1'b0}),
                        unpack_colour({r_p0_c1[15:1], 1'b0}), ax);
        n_ba = mix_rgba(unpack_colour({i_c0[15:1], 1'b0}),
                        unpack_colour({i_c1[15:1], 1'b0}), ax);
        n_tb = mix_rgba(unpack_colour(r_p0_c0[31:16]), unpack_colour(r_p0_c1[31:16]), ax);
        n_bb = mix_rgba(unpack_colour(i_c0[31:16]), unpack_colour(i_c1[31:16]), ax);
    end

    always_comb begin
        n_px = r_v_a;
        if (r_v_mode) begin
            case (r_v_sel)
                2'd0:    n_px = r_v_a;
                2'd3:    n_px = r_v_b;
                2'd2:    begin
                    n_px   = mix_rgba(r_v_a, r_v_b, 8'd128);
                    n_px.a = 8'd0;
                end
                default: n_px = mix_rgba(r_v_a, r_v_b, 8'd128);
            endcase
        end else begin
            case (r_v_sel)
                2'd0:    n_px = r_v_a;
                2'd1:    n_px = mix_rgba(r_v_a, r_v_b, 8'd96);
                2'd2:    n_px = mix_rgba(r_v_a, r_v_b, 8'd160);
                default: n_px = r_v_b;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_v_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_d_fill) begin
                r_d_valid <= 1'b1;
            end else if (rdy_h) begin
                r_d_valid <= 1'b0;
            end
            if (rdy_h) begin
                r_h_valid <= r_d_valid;
            end
            if (rdy_v) begin
                r_v_valid <= r_h_valid;
            end
            if (rdy_o) begin
                r_o_valid <= r_v_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_d_fill) begin
            r_p0_c0  <= i_c0;
            r_p0_c1  <= i_c1;
            r_p0_mod <= i_mod;
            r_d_side <= i_side;
        end
        if (rdy_h && r_d_valid) begin
            r_h_ta   <= n_ta;
            r_h_ba   <= n_ba;
            r_h_tb   <= n_tb;
            r_h_bb   <= n_bb;
            r_h_wy   <= r_d_side.wy;
            r_h_sel  <= sel;
            r_h_mode <= own[0];
        end
        if (rdy_v && r_h_valid) begin
            r_v_a    <= mix_rgba(r_h_ta, r_h_ba, {r_h_wy, 6'b000000});
            r_v_b    <= mix_rgba(r_h_tb, r_h_bb, {r_h_wy, 6'b000000});
            r_v_sel  <= r_h_sel;
            r_v_mode <= r_h_mode;
        end
        if (rdy_o && r_v_valid) begin
            r_o_px <= n_px;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.red   = r_o_px.r;
    assign o_out.green = r_o_px.g;
    assign o_out.blue  = r_o_px.b;
    assign o_out.alpha = r_o_px.a;
endmodule

[rtl/tbd_checker.sv]
`include "texel_block_decoder_4bpp_defines.svh"

module tbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);
    `TBD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `TBD_ASSERT_NEXT(a_data_hold, i_out_valid && !i_out_ready, $stable(i_out_data))
    `TBD_ASSERT_IMP(a_empty_after_reset, $past(!i_rst_n), !i_out_valid)
    `TBD_ASSERT_IMP(a_ready_after_reset, $past(!i_rst_n), i_in_ready)
endmodule

bind texel_block_decoder_4bpp tbd_checker u_tbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.red, o_out.green, o_out.blue, o_out.alpha})
);

[verif/texel_block_decoder_4bpp_checker.sv]
module texel_block_decoder_4bpp_checker
    import tbd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tbd_in_if             i_in,
    tbd_out_if            i_out,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [LW-1:0] i_cfg_data,
    output int            o_fail,
    output int            o_pending,
    output int            o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]   texture_words [512];
    logic [LW-1:0] width_reg;
    logic [LW-1:0] height_reg;
    t_rgba         texel_q [$];
    int            fail_count;
    int            checked_count;

    assign o_fail    = fail_count;
    assign o_pending = texel_q.size();
    assign o_checked = checked_count;

    function automatic int side_log2(input logic [LW-1:0] v);
        int e;
        e = int'(v);
        if (e < 2) e = 2;
        if (e > MAX_SIDE_LOG2) e = MAX_SIDE_LOG2;
        return e;
    endfunction

    function automatic int twiddle(input int bx, input int by, input int lw, input int lh);
        int lmin;
        int sq;
        int m;
        lmin = (lw < lh) ? lw : lh;
        sq = (1 << (2 * lmin)) - 1;
        m = 0;
        for (int b = 0; b < 2 * lmin; b++) begin
            if (b % 2 == 0) m |= ((by >> (b / 2)) & 1) << b;
            else m |= ((bx >> (b / 2)) & 1) << b;
        end
        if (lw > lh) m |= (bx << lh) & ~sq;
        else if (lh > lw) m |= (by << lw) & ~sq;
        return (m << 1) & 511;
    endfunction

    function automatic t_rgba expand_colour(input logic [15:0] v);
        t_rgba c;
        if (v[15]) begin
            c = '{r: {v[14:10], 3'b0}, g: {v[9:5], 3'b0}, b: {v[4:0], 3'b0}, a: 8'hFF};
        end else begin
            c = '{r: {v[11:8], 4'b0}, g: {v[7:4], 4'b0}, b: {v[3:0], 4'b0},
                  a: {v[14:12], 5'b0}};
        end
        return c;
    endfunction

    function automatic logic [7:0] blend8(input logic [7:0] s, input logic [7:0] t, input int w);
        int v;
        v = (int'(s) * (255 - w) + int'(t) * w) >> 8;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic t_rgba blend(input t_rgba s, input t_rgba t, input int w);
        t_rgba c;
        c.r = blend8(s.r, t.r, w);
        c.g = blend8(s.g, t.g, w);
        c.b = blend8(s.b, t.b, w);
        c.a = blend8(s.a, t.a, w);
        return c;
    endfunction

    function automatic t_rgba block_endpoint(input int bx, input int by, input int lw,
                                             input int lh, input bit hi);
        logic [31:0] w;
        int          px;
        int          py;
        px = (bx < 0) ? 0 : (bx > (1 << lw) - 1) ? (1 << lw) - 1 : bx;
        py = (by < 0) ? 0 : (by > (1 << lh) - 1) ? (1 << lh) - 1 : by;
        w = texture_words[(twiddle(px, py, lw, lh) + 1) & 511];
        return expand_colour(hi ? w[31:16] : {w[15:1], 1'b0});
    endfunction

    function automatic t_rgba bilerp(input int cx, input int cy, input int lw, input int lh,
                                     input int ax, input int ay, input bit hi);
        t_rgba upper;
        t_rgba lower;
        upper = blend(block_endpoint(cx, cy, lw, lh, hi),
                      block_endpoint(cx + 1, cy, lw, lh, hi), ax);
        lower = blend(block_endpoint(cx, cy + 1, lw, lh, hi),
                      block_endpoint(cx + 1, cy + 1, lw, lh, hi), ax);
        return blend(upper, lower, ay);
    endfunction

    function automatic t_rgba decode_texel(input logic [5:0] tx, input logic [5:0] ty);
        int          wl;
        int          hl;
        int          x;
        int          y;
        int          ix;
        int          iy;
        int          addr;
        int          cx;
        int          cy;
        int          sel;
        logic [31:0] mod_word;
        logic [31:0] col_word;
        t_rgba       ca;
        t_rgba       cb;
        t_rgba       res;
        wl = side_log2(width_reg);
        hl = side_log2(height_reg);
        x = int'(tx) & ((1 << wl) - 1);
        y = int'(ty) & ((1 << hl) - 1);
        ix = x & 3;
        iy = y & 3;
        addr = twiddle(x >> 2, y >> 2, wl - 2, hl - 2);
        mod_word = texture_words[addr];
        col_word = texture_words[(addr + 1) & 511];
        cx = (x >> 2) + ((ix + 2) >> 2) - 1;
        cy = (y >> 2) + ((iy + 2) >> 2) - 1;
        ca = bilerp(cx, cy, wl - 2, hl - 2, ((ix + 2) & 3) * 64, ((iy + 2) & 3) * 64, 1'b0);
        cb = bilerp(cx, cy, wl - 2, hl - 2, ((ix + 2) & 3) * 64, ((iy + 2) & 3) * 64, 1'b1);
        sel = (mod_word >> (2 * (ix + 4 * iy))) & 3;
        if (col_word[0]) begin
            if (sel == 0) res = ca;
            else if (sel == 3) res = cb;
            else begin
                res = blend(ca, cb, 128);
                if (sel == 2) res.a = 8'd0;
            end
        end else begin
            if (sel == 0) res = ca;
            else if (sel == 1) res = blend(ca, cb, 96);
            else if (sel == 2) res = blend(ca, cb, 160);
            else res = cb;
        end
        return res;
    endfunction

    initial begin
        fail_count = 0;
        checked_count = 0;
    end

    always @(posedge i_clk) begin
        t_rgba want;
        if (!i_rst_n) begin
            width_reg <= CFG_RESET;
            height_reg <= CFG_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH: width_reg <= i_cfg_data;
                    CFG_HEIGHT: height_reg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.op == OP_LOAD) texture_words[i_in.word_index] = i_in.word_data;
                else texel_q.push_back(decode_texel(i_in.texel_x, i_in.texel_y));
            end
            if (i_out.valid && i_out.ready) begin
                if (texel_q.size() == 0) begin
                    $error("unexpected texel: r=%0h g=%0h b=%0h a=%0h",
                           i_out.red, i_out.green, i_out.blue, i_out.alpha);
                    fail_count++;
                end else begin
                    want = texel_q.pop_front();
                    checked_count++;
                    if (i_out.red !== want.r) begin
                        $error("red: expected %0h actual %0h", want.r, i_out.red);
                        fail_count++;
                    end
                    if (i_out.green !== want.g) begin
                        $error("green: expected %0h actual %0h", want.g, i_out.green);
                        fail_count++;
                    end
                    if (i_out.blue !== want.b) begin
                        $error("blue: expected %0h actual %0h", want.b, i_out.blue);
                        fail_count++;
                    end
                    if (i_out.alpha !== want.a) begin
                        $error("alpha: expected %0h actual %0h", want.a, i_out.alpha);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

[verif/texel_block_decoder_4bpp_test.sv]
module texel_block_decoder_4bpp_test;
    import tbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 400000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [0:0]    i_cfg_index = '0;
    logic [LW-1:0] i_cfg_data = '0;
    int            fail_count;
    int            pending_count;
    int            checked_count;
    int            cycle_count = 0;
    int            load_count = 0;
    int            decode_count = 0;
    int            burst_left = 0;
    int            stall_mode = 0;

    tbd_in_if  in_ch ();
    tbd_out_if out_ch ();

    texel_block_decoder_4bpp u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    texel_block_decoder_4bpp_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_fail     (fail_count),
        .o_pending  (pending_count),
        .o_checked  (checked_count)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.word_index = '0;
        in_ch.word_data = '0;
        in_ch.texel_x = '0;
        in_ch.texel_y = '0;
        out_ch.ready = 1'b0;
    end

    // receiver stall pattern: free-running, random, mostly stalled, periodic
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= 1'($urandom_range(0, 1));
            2: out_ch.ready <= ($urandom_range(0, 7) == 0);
            default: out_ch.ready <= (cycle_count % 8 < 5);
        endcase
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("[texel_block_decoder_4bpp] ERROR");
            $finish;
        end
    end

    task automatic pace();
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic send_item(input t_op op, input logic [8:0] idx, input logic [31:0] data,
                             input logic [5:0] tx, input logic [5:0] ty);
        pace();
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.word_index <= idx;
        in_ch.word_data <= data;
        in_ch.texel_x <= tx;
        in_ch.texel_y <= ty;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == OP_LOAD) load_count++;
        else decode_count++;
    endtask

    task automatic load_word(input logic [8:0] idx, input logic [31:0] data);
        send_item(OP_LOAD, idx, data, '0, '0);
    endtask

    task automatic decode_at(input logic [5:0] tx, input logic [5:0] ty);
        send_item(OP_DECODE, 9'($urandom), $urandom, tx, ty);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [LW-1:0] wl, input logic [LW-1:0] hl);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data <= wl;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data <= hl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [LW-1:0] sizes [9][2];
        sizes = '{'{3'd6, 3'd6}, '{3'd2, 3'd2}, '{3'd0, 3'd7}, '{3'd6, 3'd2},
                  '{3'd2, 3'd6}, '{3'd3, 3'd5}, '{3'd7, 3'd1}, '{3'd5, 3'd4}, '{3'd4, 3'd3}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole store so that every decode reads written words
        for (int i = 0; i < 512; i++) load_word(9'(i), $urandom);

        // directed: extreme words, both modes, all modulation values, corners
        load_word(9'd0, 32'hE4E4_E4E4);
        load_word(9'd1, 32'h8001_8000);
        load_word(9'd3, 32'hFFFF_FFFF);
        load_word(9'd2, 32'h0000_0000);
        for (int i = 0; i < 4; i++) decode_at(6'(i), 6'(i));
        decode_at(6'd3, 6'd0);
        load_word(9'd1, 32'h7FFF_0000);
        for (int i = 0; i < 4; i++) decode_at(6'(i), 6'(3 - i));
        decode_at(6'd63, 6'd63);
        decode_at(6'd0, 6'd63);
        decode_at(6'd63, 6'd0);
        decode_at(6'd62, 6'd1);
        decode_at(6'd33, 6'd30);

        for (int p = 0; p < 9; p++) begin
            if (p > 0) set_size(sizes[p][0], sizes[p][1]);
            for (int n = 0; n < 115; n++) begin
                if ($urandom_range(0, 9) < 3) load_word(9'($urandom), $urandom);
                else decode_at(6'($urandom), 6'($urandom));
            end
        end
        drain();

        $display("%0d loads and %0d decodes over 9 texture sizes, %0d texels checked",
                 load_count, decode_count, checked_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[texel_block_decoder_4bpp] OK");
        end else begin
            $display("[texel_block_decoder_4bpp] ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/tbd_pkg.sv
rtl/tbd_in_if.sv
rtl/tbd_out_if.sv
rtl/tbd_store.sv
rtl/tbd_issue.sv
rtl/tbd_filter.sv
rtl/texel_block_decoder_4bpp.sv
rtl/tbd_checker.sv
verif/texel_block_decoder_4bpp_checker.sv
verif/texel_block_decoder_4bpp_test.sv
